// File: rtl/nearest_center_assign_top_assert.svh
// Assertion macros shared by the nearest-center assign RTL.
// Included by the sequencer and the top level; no other dependencies.
`ifndef NEAREST_CENTER_ASSIGN_TOP_ASSERT_SVH
`define NEAREST_CENTER_ASSIGN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is active
`define NCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define NCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCA_ASSERT(label, clk, rst_n, prop, msg)
`define NCA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/nca_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest-center assign block: field widths, codes, types.
// No dependencies; used by every other file of the block but the RAM and the assertion header.
package nca_pkg;

    // fixed field widths
    localparam int COORD_W    = 16;
    localparam int CIDX_W     = 4;
    localparam int DIDX_W     = 2;
    localparam int IDX_W      = 4;
    localparam int DIST_W     = 36;
    localparam int SQ_W       = 32;
    localparam int CENT_CFG_W = 5;
    localparam int DIMS_CFG_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [DIST_W-1:0]     DIST_MAX      = {DIST_W{1'b1}};
    localparam logic [CENT_CFG_W-1:0] CENTERS_RESET = 5'd16;
    localparam logic [DIMS_CFG_W-1:0] DIMS_RESET    = 3'd2;

    // item mode codes
    localparam logic MODE_CENTER = 1'b0;
    localparam logic MODE_POINT  = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTERS = 1'b0,
        CFG_DIMS    = 1'b1
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_LOAD
    } t_state;

    // per-step control that travels with each center-store read
    typedef struct packed {
        logic             vld;
        logic             first_dim;
        logic             last_dim;
        logic             first_ctr;
        logic             last_ctr;
        logic [IDX_W-1:0] ctr;
    } t_step_ctl;

endpackage

// File: rtl/nca_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: point/center items, results, config writes.
// Depends on nca_pkg for field widths.
interface nca_pt_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [nca_pkg::CIDX_W-1:0]       center_index;
    logic [nca_pkg::DIDX_W-1:0]       dim_index;
    logic signed [nca_pkg::COORD_W-1:0] coord_value;

    modport source (output valid, mode, center_index, dim_index, coord_value, input ready);
    modport sink   (input valid, mode, center_index, dim_index, coord_value, output ready);
endinterface

interface nca_res_if;
    logic                        valid;
    logic                        ready;
    logic [nca_pkg::IDX_W-1:0]   nearest_index;
    logic [nca_pkg::DIST_W-1:0]  squared_distance;

    modport source (output valid, nearest_index, squared_distance, input ready);
    modport sink   (input valid, nearest_index, squared_distance, output ready);
endinterface

interface nca_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [nca_pkg::CFG_IDX_W-1:0]   index;
    logic [nca_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/nca_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nca_seq.sv
`timescale 1ns / 1ps
// Sequencer: walks every (center, dimension) pair of the search, one per cycle.
// Depends on nca_pkg and the assertion macro header.
`include "nearest_center_assign_top_assert.svh"
module nca_seq #(
    parameter int NUM_CENTERS = 16,
    parameter int MAX_DIMS    = 4,
    localparam int AW  = (NUM_CENTERS * MAX_DIMS > 1) ? $clog2(NUM_CENTERS * MAX_DIMS) : 1,
    localparam int CIW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [nca_pkg::CENT_CFG_W-1:0]      i_eff_centers,
    input  logic [nca_pkg::DIMS_CFG_W-1:0]      i_eff_dims,
    input  logic                                i_done,
    input  logic                                i_out_free,
    output logic                                o_idle,
    output logic                                o_load,
    output nca_pkg::t_step_ctl                  o_ctl,
    output logic [AW-1:0]                       o_raddr,
    output logic [nca_pkg::DIMS_CFG_W-1:0]      o_dim
);

    nca_pkg::t_state               r_state, n_state;
    logic [CIW-1:0]                r_ctr, n_ctr;
    logic [nca_pkg::DIMS_CFG_W-1:0] r_dim, n_dim;
    logic [AW-1:0]                 r_base, n_base;
    logic                          last_dim;
    logic                          last_ctr;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nca_pkg::S_IDLE;
            r_ctr   <= '0;
            r_dim   <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_dim   <= n_dim;
            r_base  <= n_base;
        end
    end

    assign last_dim = (r_dim == i_eff_dims - 3'd1);
    assign last_ctr = (32'(r_ctr) == 32'(i_eff_centers) - 32'd1);

    // next state and step control
    always_comb begin
        n_state = r_state;
        n_ctr   = r_ctr;
        n_dim   = r_dim;
        n_base  = r_base;
        o_load  = 1'b0;
        o_ctl   = '0;
        case (r_state)
            nca_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = nca_pkg::S_RUN;
                    n_ctr   = '0;
                    n_dim   = '0;
                    n_base  = '0;
                end
            end
            nca_pkg::S_RUN: begin
                o_ctl.vld       = 1'b1;
                o_ctl.first_dim = (r_dim == '0);
                o_ctl.last_dim  = last_dim;
                o_ctl.first_ctr = (r_ctr == '0);
                o_ctl.last_ctr  = last_ctr;
                o_ctl.ctr       = nca_pkg::IDX_W'(r_ctr);
                if (last_dim) begin
                    n_dim = '0;
                    if (last_ctr) begin
                        n_state = nca_pkg::S_DRAIN;
                    end else begin
                        n_ctr  = r_ctr + 1'b1;
                        n_base = r_base + AW'(MAX_DIMS);
                    end
                end else begin
                    n_dim = r_dim + 3'd1;
                end
            end
            nca_pkg::S_DRAIN: begin
                if (i_done) begin
                    n_state = nca_pkg::S_LOAD;
                end
            end
            nca_pkg::S_LOAD: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = nca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nca_pkg::S_IDLE;
            end
        endcase
    end

    assign o_raddr = r_base + AW'(r_dim);
    assign o_dim   = r_dim;
    assign o_idle  = (r_state == nca_pkg::S_IDLE);

    // the arithmetic pipeline finishes only after the last read was issued
    `NCA_ASSERT(a_done_in_drain, i_clk, i_rst_n, i_done |-> (r_state == nca_pkg::S_DRAIN), "search finished outside drain state")
    `NCA_ASSERT_ALWAYS(a_reset_to_idle, i_clk, !i_rst_n |=> (r_state == nca_pkg::S_IDLE), "sequencer not idle after reset")

endmodule

// File: rtl/nca_dist.sv
`timescale 1ns / 1ps
// Shared distance unit: subtract, square, accumulate per dimension, then
// keep the running minimum over centers. Depends on nca_pkg.
module nca_dist #(
    parameter int MAX_DIMS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nca_pkg::t_step_ctl             i_ctl,
    input  nca_pkg::t_coord                i_pt_coord,
    input  logic [nca_pkg::COORD_W-1:0]    i_ctr_coord,
    output logic                           o_done,
    output logic [nca_pkg::IDX_W-1:0]      o_best_idx,
    output logic [nca_pkg::DIST_W-1:0]     o_best_dist
);

    localparam int SUM_W = nca_pkg::SQ_W + $clog2(MAX_DIMS + 1);
    localparam int ACC_W = (SUM_W > nca_pkg::DIST_W) ? SUM_W : nca_pkg::DIST_W;

    nca_pkg::t_step_ctl                r_ctl1, r_ctl2;
    nca_pkg::t_coord                   r_pt1;
    logic signed [nca_pkg::COORD_W:0]  diff;
    logic signed [2*nca_pkg::COORD_W+1:0] prod;
    logic [nca_pkg::SQ_W-1:0]          r_sq;
    logic [ACC_W-1:0]                  r_acc;
    logic [ACC_W-1:0]                  acc_sum;
    logic [nca_pkg::DIST_W-1:0]        cand;
    logic                              take;
    logic [nca_pkg::DIST_W-1:0]        r_best;
    logic [nca_pkg::IDX_W-1:0]         r_best_idx;
    logic                              r_done;

    // stage 1 lines the point coordinate up with the registered RAM read;
    // stage 2 squares the difference
    assign diff = {r_pt1[nca_pkg::COORD_W-1], r_pt1}
                - {i_ctr_coord[nca_pkg::COORD_W-1], i_ctr_coord};
    assign prod = diff * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt1 <= i_pt_coord;
        r_sq  <= prod[nca_pkg::SQ_W-1:0];
    end

    // stage 3: accumulate, saturate, compare against the best so far
    assign acc_sum = (r_ctl2.first_dim ? '0 : r_acc) + ACC_W'(r_sq);
    assign cand    = (acc_sum > ACC_W'(nca_pkg::DIST_MAX)) ? nca_pkg::DIST_MAX
                                                           : nca_pkg::DIST_W'(acc_sum);
    assign take    = r_ctl2.vld && r_ctl2.last_dim && (r_ctl2.first_ctr || (cand < r_best));

    always_ff @(posedge i_clk) begin
        if (r_ctl2.vld) begin
            r_acc <= acc_sum;
        end
        if (take) begin
            r_best     <= cand;
            r_best_idx <= r_ctl2.ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ctl2.vld && r_ctl2.last_dim && r_ctl2.last_ctr;
        end
    end

    assign o_done      = r_done;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best;

endmodule

// File: rtl/nearest_center_assign_top.sv
`timescale 1ns / 1ps
// Top level of the nearest-center assign block: config registers, point
// buffer, center store, sequencer, distance unit, result register.
// Depends on nca_pkg, nca_channels, nca_ram, nca_seq, nca_dist, assert header.
//
//   channel  | dir | handshake    | payload
//   i_pt     | in  | valid/ready  | mode, center_index, dim_index, coord_value
//   o_res    | out | valid/ready  | nearest_index, squared_distance
//   i_cfg    | in  | valid/ready  | index, data
//
// A center write or a point coordinate that does not close the point is only
// stored. The coordinate that closes a point starts a search: one distance
// unit reads the center store once per (center, dimension) pair through its
// single read port.
// i_pt.ready is low during a search and while its result waits to load.
// A stalled result holds in the output register; the config port is always ready.
// Reset is synchronous, active low; the center store needs no clearing.
`include "nearest_center_assign_top_assert.svh"
module nearest_center_assign_top #(
    parameter int NUM_CENTERS = 16,
    parameter int MAX_DIMS    = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nca_pt_if.sink     i_pt,
    nca_res_if.source  o_res,
    nca_cfg_if.sink    i_cfg
);

    localparam int DEPTH = NUM_CENTERS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PB_D  = (MAX_DIMS < 4) ? MAX_DIMS : 4;
    localparam int PB_IW = (PB_D > 1) ? $clog2(PB_D) : 1;

    logic [nca_pkg::CENT_CFG_W-1:0] r_centers;
    logic [nca_pkg::DIMS_CFG_W-1:0] r_dims;
    logic [nca_pkg::CENT_CFG_W-1:0] eff_centers;
    logic [nca_pkg::DIMS_CFG_W-1:0] eff_dims;

    logic                           in_acc;
    logic                           dim_ok;
    logic                           ctr_we;
    logic                           pt_we;
    logic                           seq_start;
    logic [AW-1:0]                  waddr;

    nca_pkg::t_coord                r_pbuf [PB_D];

    logic                           seq_idle;
    logic                           seq_load;
    nca_pkg::t_step_ctl             seq_ctl;
    logic [AW-1:0]                  seq_raddr;
    logic [nca_pkg::DIMS_CFG_W-1:0] seq_dim;
    logic [nca_pkg::COORD_W-1:0]    ram_rdata;

    logic                           dist_done;
    logic [nca_pkg::IDX_W-1:0]      best_idx;
    logic [nca_pkg::DIST_W-1:0]     best_dist;

    logic                           out_free;
    logic                           r_out_valid;
    logic [nca_pkg::IDX_W-1:0]      r_out_idx;
    logic [nca_pkg::DIST_W-1:0]     r_out_dist;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centers <= nca_pkg::CENTERS_RESET;
            r_dims    <= nca_pkg::DIMS_RESET;
        end else if (i_cfg.valid) begin
            case (nca_pkg::t_cfg_reg'(i_cfg.index))
                nca_pkg::CFG_CENTERS: r_centers <= i_cfg.data[nca_pkg::CENT_CFG_W-1:0];
                nca_pkg::CFG_DIMS:    r_dims    <= i_cfg.data[nca_pkg::DIMS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, large values clamp to the built size
    always_comb begin
        if (r_centers == '0) begin
            eff_centers = 5'd1;
        end else if (32'(r_centers) > NUM_CENTERS) begin
            eff_centers = nca_pkg::CENT_CFG_W'(NUM_CENTERS);
        end else begin
            eff_centers = r_centers;
        end
        if (r_dims == '0) begin
            eff_dims = 3'd1;
        end else if (32'(r_dims) > MAX_DIMS) begin
            eff_dims = nca_pkg::DIMS_CFG_W'(MAX_DIMS);
        end else begin
            eff_dims = r_dims;
        end
    end

    // input item decode
    assign i_pt.ready = seq_idle;
    assign in_acc     = i_pt.valid && i_pt.ready;
    assign dim_ok     = nca_pkg::DIMS_CFG_W'(i_pt.dim_index) < eff_dims;
    assign ctr_we     = in_acc && (i_pt.mode == nca_pkg::MODE_CENTER) && dim_ok
                     && (32'(i_pt.center_index) < NUM_CENTERS);
    assign pt_we      = in_acc && (i_pt.mode == nca_pkg::MODE_POINT) && dim_ok;
    assign seq_start  = pt_we && (nca_pkg::DIMS_CFG_W'(i_pt.dim_index) == eff_dims - 3'd1);
    assign waddr      = AW'(32'(i_pt.center_index) * MAX_DIMS + 32'(i_pt.dim_index));

    // point buffer
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pbuf[i_pt.dim_index[PB_IW-1:0]] <= i_pt.coord_value;
        end
    end

    // center store
    nca_ram #(
        .WIDTH (nca_pkg::COORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (waddr),
        .i_wdata (i_pt.coord_value),
        .i_raddr (seq_raddr),
        .o_rdata (ram_rdata)
    );

    nca_seq #(
        .NUM_CENTERS (NUM_CENTERS),
        .MAX_DIMS    (MAX_DIMS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (seq_start),
        .i_eff_centers (eff_centers),
        .i_eff_dims    (eff_dims),
        .i_done        (dist_done),
        .i_out_free    (out_free),
        .o_idle        (seq_idle),
        .o_load        (seq_load),
        .o_ctl         (seq_ctl),
        .o_raddr       (seq_raddr),
        .o_dim         (seq_dim)
    );

    nca_dist #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (seq_ctl),
        .i_pt_coord  (r_pbuf[seq_dim[PB_IW-1:0]]),
        .i_ctr_coord (ram_rdata),
        .o_done      (dist_done),
        .o_best_idx  (best_idx),
        .o_best_dist (best_dist)
    );

    // result register
    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_load) begin
            r_out_idx  <= best_idx;
            r_out_dist <= best_dist;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.nearest_index    = r_out_idx;
    assign o_res.squared_distance = r_out_dist;

    // a pending result is never overwritten, and a closing coordinate starts a search
    `NCA_ASSERT(a_load_when_free, i_clk, i_rst_n, seq_load |-> (!r_out_valid || o_res.ready), "result register overwritten")
    `NCA_ASSERT(a_start_leaves_idle, i_clk, i_rst_n, seq_start |=> !seq_idle, "closing coordinate did not start a search")

endmodule

// File: tb/sv/nca_assign_checker.sv
`timescale 1ns / 1ps
// Checker for the nearest-center assign block: watches the point, result and
// config channels, predicts each assignment and compares it field by field.
// Depends on nca_pkg and the channel interfaces in nca_channels.
module nca_assign_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nca_pt_if    i_pt,
    nca_res_if   i_res,
    nca_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import nca_pkg::*;

    localparam int NCTR = 16;
    localparam int NDIM = 4;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sqd;
    } t_assign;

    // shadow copy of the block's state and registers
    t_coord                ctr_tab [0:NCTR-1][0:NDIM-1];
    t_coord                pt_buf  [0:NDIM-1];
    logic [CENT_CFG_W-1:0] centers_reg;
    logic [DIMS_CFG_W-1:0] dims_reg;

    t_assign assign_q[$];
    int      err_count = 0;
    int      pending_n = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_n;

    // zero acts as one, large values saturate
    function automatic int clamp_count(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // exact squared distance from the buffered point to center c
    function automatic logic [DIST_W-1:0] sq_dist(input int c, input int nd);
        longint acc;
        longint diff;
        int     d;
        acc = 0;
        for (d = 0; d < nd; d++) begin
            diff = longint'(pt_buf[d]) - longint'(ctr_tab[c][d]);
            acc += diff * diff;
        end
        if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
        return acc[DIST_W-1:0];
    endfunction

    // lowest index with the least distance, strict less-than
    function automatic t_assign closest_center(input int nc, input int nd);
        t_assign           best;
        logic [DIST_W-1:0] dd;
        int                c;
        best.idx = '0;
        best.sqd = sq_dist(0, nd);
        for (c = 1; c < nc; c++) begin
            dd = sq_dist(c, nd);
            if (dd < best.sqd) begin
                best.sqd = dd;
                best.idx = c[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_assign got;
        t_assign want;
        int      nd;
        if (!i_rst_n) begin
            centers_reg = CENTERS_RESET;
            dims_reg    = DIMS_RESET;
            assign_q.delete();
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_CENTERS) begin
                    centers_reg = i_cfg.data[CENT_CFG_W-1:0];
                end else begin
                    dims_reg = i_cfg.data[DIMS_CFG_W-1:0];
                end
            end

            // result side: compare against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                got.idx = i_res.nearest_index;
                got.sqd = i_res.squared_distance;
                if (assign_q.size() == 0) begin
                    report_mismatch($sformatf("result idx %0d dist %0d with nothing expected",
                                              got.idx, got.sqd));
                end else begin
                    want = assign_q.pop_front();
                    if (got.idx !== want.idx)
                        report_mismatch($sformatf("nearest_index got %0d expected %0d",
                                                  got.idx, want.idx));
                    if (got.sqd !== want.sqd)
                        report_mismatch($sformatf("squared_distance got %0d expected %0d",
                                                  got.sqd, want.sqd));
                end
            end

            // input side: update the shadow state, predict on the closing coordinate
            if (i_pt.valid && i_pt.ready) begin
                nd = clamp_count(int'(dims_reg), NDIM);
                if (int'(i_pt.dim_index) < nd) begin
                    if (i_pt.mode == MODE_CENTER) begin
                        ctr_tab[i_pt.center_index][i_pt.dim_index] = i_pt.coord_value;
                    end else begin
                        pt_buf[i_pt.dim_index] = i_pt.coord_value;
                        if (int'(i_pt.dim_index) == nd - 1)
                            assign_q.push_back(
                                closest_center(clamp_count(int'(centers_reg), NCTR), nd));
                    end
                end
            end
        end
        pending_n = assign_q.size();
    end

endmodule

// File: tb/sv/nearest_center_assign_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for nearest_center_assign_top: clock, reset, point/center and
// config stimulus, result-side stalls and the verdict.
// Depends on nca_pkg, nca_channels, the block and nca_assign_checker.
module nearest_center_assign_top_tb;
    import nca_pkg::*;

    localparam int NCTR          = 16;
    localparam int NDIM          = 4;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int NPHASE        = 10;
    localparam int PHASE_ITEMS   = 200;

    // register settings per random phase; the last one is drawn at run time
    localparam int PH_CENTERS [NPHASE] = '{1, 0, 31, 16, 7, 2, 16, 12, 17, 16};
    localparam int PH_DIMS    [NPHASE] = '{1, 0, 7, 4, 3, 4, 1, 2, 5, 4};

    logic i_clk = 1'b0;
    logic i_rst_n;

    nca_pt_if  pt_ch ();
    nca_res_if res_ch ();
    nca_cfg_if cfg_ch ();

    int   errors;
    int   pending;
    int   cycles = 0;
    int   dims_eff = 2;
    bit   calm = 1'b0;
    bit   hold_long = 1'b0;
    t_coord tie_vec [0:NDIM-1];

    nearest_center_assign_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    nca_assign_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (pt_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("nearest_center_assign_top_tb: errors");
            $finish;
        end
    end

    // coordinates: extremes, a small range that makes ties likely, full range
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return t_coord'(int'($urandom_range(0, 4)) - 2);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // offer one item, with an occasional gap before it; valid stays high after
    task automatic send_item(input logic m, input logic [CIDX_W-1:0] c,
                             input logic [DIDX_W-1:0] d, input t_coord v);
        if (!calm && $urandom_range(0, 7) == 0) begin
            pt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        pt_ch.valid        <= 1'b1;
        pt_ch.mode         <= m;
        pt_ch.center_index <= c;
        pt_ch.dim_index    <= d;
        pt_ch.coord_value  <= v;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic wait_idle();
        pt_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write; bits above the register width are random or zero
    task automatic write_reg(input t_cfg_reg r, input int v);
        logic [CFG_DATA_W-1:0] bits;
        bits = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 0) bits = '0;
        if (r == CFG_CENTERS) bits[CENT_CFG_W-1:0] = v[CENT_CFG_W-1:0];
        else bits[DIMS_CFG_W-1:0] = v[DIMS_CFG_W-1:0];
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= bits;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int cv, input int dv);
        wait_idle();
        write_reg(CFG_CENTERS, cv);
        write_reg(CFG_DIMS, dv);
        cfg_ch.valid <= 1'b0;
        dims_eff = (dv[DIMS_CFG_W-1:0] == 0) ? 1 :
                   (int'(dv[DIMS_CFG_W-1:0]) > NDIM) ? NDIM : int'(dv[DIMS_CFG_W-1:0]);
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        int p;
        int sent;
        int kind;
        int c;
        int d;
        int cv;
        int dv;
        logic [DIDX_W-1:0] nd_raw;

        pt_ch.valid        = 1'b0;
        pt_ch.mode         = MODE_CENTER;
        pt_ch.center_index = '0;
        pt_ch.dim_index    = '0;
        pt_ch.coord_value  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_CENTERS;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every center entry at full width so no read ever hits an unwritten one
        set_config(16, 4);
        for (d = 0; d < NDIM; d++) tie_vec[d] = t_coord'($urandom);
        for (c = 0; c < NCTR; c++) begin
            for (d = 0; d < NDIM; d++) begin
                if (c == 0)
                    send_item(MODE_CENTER, 4'(c), 2'(d), 16'sh7fff);
                else if (c == 1)
                    send_item(MODE_CENTER, 4'(c), 2'(d), 16'sh8000);
                else if (c == 5 || c == 9)
                    send_item(MODE_CENTER, 4'(c), 2'(d), tie_vec[d]);
                else
                    send_item(MODE_CENTER, 4'(c), 2'(d), rand_coord());
            end
        end

        // directed: exact hit on the most negative center
        for (d = 0; d < NDIM; d++) send_item(MODE_POINT, 4'd0, 2'(d), 16'sh8000);
        // tie between two identical centers goes to the lower index
        for (d = 0; d < NDIM; d++) send_item(MODE_POINT, 4'd3, 2'(d), tie_vec[d]);
        // stale point: only the closing coordinate is resent
        send_item(MODE_POINT, 4'd15, 2'd3, 16'sh7fff);
        send_item(MODE_POINT, 4'd0, 2'd1, 16'sh0000);
        send_item(MODE_CENTER, 4'd15, 2'd2, 16'sh7fff);

        // single center in use: largest possible distance
        set_config(1, 4);
        for (d = 0; d < NDIM; d++) send_item(MODE_POINT, 4'd0, 2'(d), 16'sh8000);

        // zero registers act as one; higher dimensions are ignored in both modes
        set_config(0, 0);
        send_item(MODE_POINT, 4'd0, 2'd3, 16'sh1234);
        send_item(MODE_CENTER, 4'd3, 2'd2, 16'sh0042);
        send_item(MODE_POINT, 4'd9, 2'd0, 16'sh0005);

        // registers above range saturate
        set_config(31, 7);
        send_item(MODE_POINT, 4'd0, 2'd0, 16'sh7fff);
        send_item(MODE_POINT, 4'd0, 2'd1, 16'sh8000);
        send_item(MODE_POINT, 4'd0, 2'd2, 16'sh7fff);
        send_item(MODE_POINT, 4'd0, 2'd3, 16'sh8000);

        set_config(16, 2);
        send_item(MODE_POINT, 4'd0, 2'd3, 16'sh7fff);
        send_item(MODE_POINT, 4'd0, 2'd2, 16'sh7fff);
        send_item(MODE_POINT, 4'd0, 2'd0, 16'sh0001);
        send_item(MODE_POINT, 4'd0, 2'd1, 16'shffff);

        // random phases: mostly whole points and whole centers, some noise
        for (p = 0; p < NPHASE; p++) begin
            calm = (p == NPHASE - 1);
            cv = (p == NPHASE - 1) ? int'($urandom_range(0, 31)) : PH_CENTERS[p];
            dv = (p == NPHASE - 1) ? int'($urandom_range(0, 7)) : PH_DIMS[p];
            set_config(cv, dv);
            if (p == 2) hold_long = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    for (d = 0; d < dims_eff; d++)
                        send_item(MODE_POINT, 4'($urandom), 2'(d), rand_coord());
                    sent += dims_eff;
                end else if (kind < 7) begin
                    c = $urandom_range(0, NCTR - 1);
                    for (d = 0; d < dims_eff; d++)
                        send_item(MODE_CENTER, 4'(c), 2'(d), rand_coord());
                    sent += dims_eff;
                end else begin
                    nd_raw = 2'($urandom);
                    send_item(($urandom_range(0, 1) == 0) ? MODE_CENTER : MODE_POINT,
                              4'($urandom), nd_raw, rand_coord());
                    if (int'(nd_raw) < dims_eff) sent++;
                end
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("nearest_center_assign_top_tb: clean");
        end else begin
            $display("nearest_center_assign_top_tb: errors");
        end
        $finish;
    end

endmodule
